// File: src/lpb_pkg.sv
// shared types and constants of the lru page buffer controller
`timescale 1ns / 1ps
package lpb_pkg;

    localparam int NUM_FRAMES_DEF    = 16;
    localparam int PAGE_NUM_BITS_DEF = 32;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  table_number;
        logic [31:0] page_number;
    } t_in_req;

    typedef struct packed {
        logic        hit;
        logic [3:0]  frame_index;
        logic        fetch_needed;
        logic        evict_valid;
        logic        writeback;
        logic [3:0]  evict_table;
        logic [31:0] evict_page;
        logic        last;
    } t_out_res;

endpackage

// File: src/lpb_tag_ram.sv
// tag memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module lpb_tag_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/lru_page_buffer_controller.sv
// lru page buffer controller top level: tag lookup, eviction and table close
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------
//  request | in        | i_in_valid / o_in_stall  | i_in_req  (t_in_req)
//  result  | out       | o_out_valid / i_out_stall| o_out_res (t_out_res)
//
// read/write: lookup walks the used frames in recency order, one tag memory
// read per cycle until a match or the end of the used frames, plus one read on eviction
// close table: each used frame is read, then compared (S_CRD, then S_CCMP)
// one request at a time; the request side stalls until the last result is registered
// synchronous active-low reset empties the buffer; the tag memory is not cleared
`timescale 1ns / 1ps
module lru_page_buffer_controller
    import lpb_pkg::*;
#(
    parameter int NUM_FRAMES    = NUM_FRAMES_DEF,
    parameter int PAGE_NUM_BITS = PAGE_NUM_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int UW = $clog2(NUM_FRAMES + 1);
    localparam int PB = PAGE_NUM_BITS;
    localparam int TW = 4 + PB;
    localparam logic [UW-1:0] FULL    = UW'(NUM_FRAMES);
    localparam logic [FW-1:0] LASTPOS = FW'(NUM_FRAMES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_CRD  = 3'd3;
    localparam logic [2:0] S_CCMP = 3'd4;

    localparam logic [1:0] ORD_NONE  = 2'd0;
    localparam logic [1:0] ORD_FRONT = 2'd1;
    localparam logic [1:0] ORD_REL   = 2'd2;

    logic [2:0]    r_state, n_state;
    t_in_req       r_req;
    logic [UW-1:0] r_p, n_p;
    logic [FW-1:0] r_q, n_q;
    logic          r_cv, n_cv;
    logic [UW-1:0] r_used, n_used;
    logic [FW-1:0] r_order [NUM_FRAMES];
    logic [FW-1:0] n_order [NUM_FRAMES];
    logic          r_dirty [NUM_FRAMES];
    logic          r_ovalid;
    t_out_res      r_ores;

    logic          emit;
    t_out_res      res;
    logic [1:0]    ord_mode;
    logic [FW-1:0] ord_pos;
    logic          d_we, d_val;
    logic [FW-1:0] d_frame;
    logic          rd_en, wr_en;
    logic [FW-1:0] rd_addr, wr_addr;
    logic [TW-1:0] rd_data;
    logic [TW-1:0] req_tag;
    logic [PB+31:0] pg_ext;
    logic [PB+31:0] ep_ext;
    logic [3:0]    rd_tbl;
    logic          ofree;
    logic          tag_match;
    logic [FW-1:0] f_q, f_p, f_used;

    function automatic logic [3:0] fr4(input logic [FW-1:0] f);
        logic [FW+3:0] t;
        t = {4'b0, f};
        return t[3:0];
    endfunction

    lpb_tag_ram #(
        .DEPTH(NUM_FRAMES),
        .WIDTH(TW)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (req_tag)
    );

    assign pg_ext    = {{PB{1'b0}}, r_req.page_number};
    assign req_tag   = {r_req.table_number, pg_ext[PB-1:0]};
    assign ep_ext    = {32'b0, rd_data[PB-1:0]};
    assign rd_tbl    = rd_data[TW-1 -: 4];
    assign ofree     = !r_ovalid || !i_out_stall;
    assign tag_match = r_cv && (rd_data == req_tag);
    assign f_q       = r_order[r_q];
    assign f_p       = r_order[r_p[FW-1:0]];
    assign f_used    = r_order[r_used[FW-1:0]];

    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_q      = r_q;
        n_cv     = r_cv;
        n_used   = r_used;
        emit     = 1'b0;
        res      = '0;
        ord_mode = ORD_NONE;
        ord_pos  = '0;
        d_we     = 1'b0;
        d_val    = 1'b0;
        d_frame  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_p  = '0;
                    n_cv = 1'b0;
                    if (i_in_req.operation == OP_READ || i_in_req.operation == OP_WRITE) begin
                        n_state = S_SCAN;
                    end else if (i_in_req.operation == OP_CLOSE) begin
                        n_state = S_CRD;
                    end
                end
            end
            S_SCAN: begin
                if (tag_match) begin
                    if (ofree) begin
                        emit            = 1'b1;
                        res.hit         = 1'b1;
                        res.frame_index = fr4(f_q);
                        res.last        = 1'b1;
                        ord_mode        = ORD_FRONT;
                        ord_pos         = r_q;
                        d_we            = (r_req.operation == OP_WRITE);
                        d_val           = 1'b1;
                        d_frame         = f_q;
                        n_state         = S_IDLE;
                    end
                end else if (r_p == r_used) begin
                    if (r_used == FULL) begin
                        rd_en   = 1'b1;
                        rd_addr = r_order[LASTPOS];
                        n_state = S_EV;
                    end else if (ofree) begin
                        emit             = 1'b1;
                        res.frame_index  = fr4(f_used);
                        res.fetch_needed = (r_req.operation == OP_READ);
                        res.last         = 1'b1;
                        ord_mode         = ORD_FRONT;
                        ord_pos          = r_used[FW-1:0];
                        n_used           = r_used + 1'b1;
                        wr_en            = 1'b1;
                        wr_addr          = f_used;
                        d_we             = 1'b1;
                        d_val            = (r_req.operation == OP_WRITE);
                        d_frame          = f_used;
                        n_state          = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = f_p;
                    n_q     = r_p[FW-1:0];
                    n_cv    = 1'b1;
                    n_p     = r_p + 1'b1;
                end
            end
            S_EV: begin
                if (ofree) begin
                    emit             = 1'b1;
                    res.frame_index  = fr4(r_order[LASTPOS]);
                    res.fetch_needed = (r_req.operation == OP_READ);
                    res.evict_valid  = 1'b1;
                    res.writeback    = r_dirty[r_order[LASTPOS]];
                    res.evict_table  = rd_tbl;
                    res.evict_page   = ep_ext[31:0];
                    res.last         = 1'b1;
                    ord_mode         = ORD_FRONT;
                    ord_pos          = LASTPOS;
                    wr_en            = 1'b1;
                    wr_addr          = r_order[LASTPOS];
                    d_we             = 1'b1;
                    d_val            = (r_req.operation == OP_WRITE);
                    d_frame          = r_order[LASTPOS];
                    n_state          = S_IDLE;
                end
            end
            S_CRD: begin
                if (r_p < r_used) begin
                    rd_en   = 1'b1;
                    rd_addr = f_p;
                    n_state = S_CCMP;
                end else if (ofree) begin
                    emit     = 1'b1;
                    res.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CCMP: begin
                if (rd_tbl == r_req.table_number) begin
                    if (ofree) begin
                        emit            = 1'b1;
                        res.frame_index = fr4(f_p);
                        res.evict_valid = 1'b1;
                        res.writeback   = r_dirty[f_p];
                        res.evict_table = rd_tbl;
                        res.evict_page  = ep_ext[31:0];
                        ord_mode        = ORD_REL;
                        ord_pos         = r_p[FW-1:0];
                        n_used          = r_used - 1'b1;
                        d_we            = 1'b1;
                        d_val           = 1'b0;
                        d_frame         = f_p;
                        n_state         = S_CRD;
                    end
                end else begin
                    n_p     = r_p + 1'b1;
                    n_state = S_CRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            n_order[i] = r_order[i];
            case (ord_mode)
                ORD_FRONT: begin
                    if (i == 0) begin
                        n_order[i] = r_order[ord_pos];
                    end else if (i <= int'(ord_pos)) begin
                        n_order[i] = r_order[i - 1];
                    end
                end
                ORD_REL: begin
                    if (i == int'(r_used) - 1) begin
                        n_order[i] = r_order[ord_pos];
                    end else if (i >= int'(ord_pos) && i + 1 < int'(r_used)) begin
                        n_order[i] = r_order[(i + 1 < NUM_FRAMES) ? i + 1 : i];
                    end
                end
                default: begin
                    n_order[i] = r_order[i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p      <= '0;
            r_q      <= '0;
            r_cv     <= 1'b0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_order[i] <= FW'(i);
                r_dirty[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_q     <= n_q;
            r_cv    <= n_cv;
            r_used  <= n_used;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_order[i] <= n_order[i];
            end
            if (d_we) begin
                r_dirty[d_frame] <= d_val;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (emit) begin
            r_ores <= res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_res   = r_ores;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL)
        else $error("used count above frame count");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used == $past(r_used) || r_used == $past(r_used) + 1'b1
                            || r_used == $past(r_used) - 1'b1))
        else $error("used count jumped");

    a_lookup_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid
         && (i_in_req.operation == OP_READ || i_in_req.operation == OP_WRITE))
        |=> (r_state == S_SCAN && r_p == '0 && !r_cv))
        else $error("lookup did not start from the front");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> (r_ores == $past(r_ores)))
        else $error("result overwritten while stalled");

endmodule

// File: verif/lru_page_buffer_controller_test.sv
// self-checking testbench for the lru page buffer controller
`timescale 1ns / 1ps
module lru_page_buffer_controller_test;
    import lpb_pkg::*;

    localparam int FRAMES = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_res o_out_res;

    lru_page_buffer_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

    // shadow of the buffer state
    logic [3:0]  tag_table [FRAMES];
    logic [31:0] tag_page [FRAMES];
    logic        dirty [FRAMES];
    logic [3:0]  recency [FRAMES];
    int          frames_used;

    t_in_req  pending_requests[$];
    t_out_res expected_results[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_requests;
    bit       in_taken;
    int       error_count;
    int       quiet_cycles;

    function automatic t_out_res make_result(logic hit, logic [3:0] frame, logic fetch,
                                             logic ev, logic wb, logic [3:0] et,
                                             logic [31:0] ep, logic last);
        t_out_res r;
        r.hit = hit; r.frame_index = frame; r.fetch_needed = fetch;
        r.evict_valid = ev; r.writeback = wb; r.evict_table = et;
        r.evict_page = ep; r.last = last;
        return r;
    endfunction

    task automatic move_to_front(int pos);
        logic [3:0] f;
        f = recency[pos];
        for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
        recency[0] = f;
    endtask

    task automatic predict_buffer_access(t_in_req req);
        logic [3:0]  f;
        logic        ev, wb;
        logic [3:0]  et;
        logic [31:0] ep;
        int          p;
        ev = 0; wb = 0; et = 0; ep = 0;
        if (req.operation == OP_READ || req.operation == OP_WRITE) begin
            for (p = 0; p < frames_used; p++) begin
                f = recency[p];
                if (tag_table[f] == req.table_number && tag_page[f] == req.page_number) begin
                    move_to_front(p);
                    if (req.operation == OP_WRITE) dirty[f] = 1;
                    expected_results.push_back(make_result(1, f, 0, 0, 0, 0, 0, 1));
                    return;
                end
            end
            if (frames_used >= FRAMES) begin
                frames_used = FRAMES - 1;
                f = recency[frames_used];
                ev = 1; wb = dirty[f]; et = tag_table[f]; ep = tag_page[f];
            end
            f = recency[frames_used];
            move_to_front(frames_used);
            frames_used++;
            tag_table[f] = req.table_number;
            tag_page[f] = req.page_number;
            dirty[f] = (req.operation == OP_WRITE);
            expected_results.push_back(make_result(0, f, req.operation == OP_READ,
                                                   ev, wb, et, ep, 1));
        end else if (req.operation == OP_CLOSE) begin
            p = 0;
            while (p < frames_used) begin
                f = recency[p];
                if (tag_table[f] == req.table_number) begin
                    expected_results.push_back(make_result(0, f, 0, 1, dirty[f],
                                                           tag_table[f], tag_page[f], 0));
                    for (int i = p; i + 1 < frames_used; i++) recency[i] = recency[i+1];
                    recency[frames_used-1] = f;
                    frames_used--;
                    dirty[f] = 0;
                end else begin
                    p++;
                end
            end
            expected_results.push_back(make_result(0, 0, 0, 0, 0, 0, 0, 1));
        end
    endtask

    task automatic add_request(logic [1:0] op, logic [3:0] tbl, logic [31:0] pg);
        t_in_req r;
        r.operation = op; r.table_number = tbl; r.page_number = pg;
        pending_requests.push_back(r);
    endtask

    // small working set so hits, evictions and closes all occur
    task automatic add_random_request();
        int sel;
        logic [1:0]  op;
        logic [31:0] pg;
        sel = $urandom_range(0, 99);
        if (sel < 45) op = OP_READ;
        else if (sel < 88) op = OP_WRITE;
        else if (sel < 96) op = OP_CLOSE;
        else op = OP_UNKNOWN;
        if ($urandom_range(0, 9) < 8) pg = $urandom_range(0, 7);
        else pg = $urandom;
        add_request(op, $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3)),
                    pg);
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            in_taken = 0;
        end else if (i_in_valid && !in_taken) begin
            // hold stalled request
        end else begin
            in_taken = 0;
            if (!hold_requests && pending_requests.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1;
                i_in_req <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && !o_in_stall) begin
                predict_buffer_access(i_in_req);
                in_taken = 1;
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (expected_results.size() == 0) begin
                    $error("result with no expectation: %p", o_out_res);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_res.hit !== want.hit) begin
                        $error("hit exp %0h got %0h", want.hit, o_out_res.hit); error_count++;
                    end
                    if (o_out_res.frame_index !== want.frame_index) begin
                        $error("frame_index exp %0h got %0h", want.frame_index,
                               o_out_res.frame_index); error_count++;
                    end
                    if (o_out_res.fetch_needed !== want.fetch_needed) begin
                        $error("fetch_needed exp %0h got %0h", want.fetch_needed,
                               o_out_res.fetch_needed); error_count++;
                    end
                    if (o_out_res.evict_valid !== want.evict_valid) begin
                        $error("evict_valid exp %0h got %0h", want.evict_valid,
                               o_out_res.evict_valid); error_count++;
                    end
                    if (o_out_res.writeback !== want.writeback) begin
                        $error("writeback exp %0h got %0h", want.writeback,
                               o_out_res.writeback); error_count++;
                    end
                    if (o_out_res.evict_table !== want.evict_table) begin
                        $error("evict_table exp %0h got %0h", want.evict_table,
                               o_out_res.evict_table); error_count++;
                    end
                    if (o_out_res.evict_page !== want.evict_page) begin
                        $error("evict_page exp %0h got %0h", want.evict_page,
                               o_out_res.evict_page); error_count++;
                    end
                    if (o_out_res.last !== want.last) begin
                        $error("last exp %0h got %0h", want.last, o_out_res.last);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic wait_until_drained();
        while (!(pending_requests.size() == 0 && !i_in_valid &&
                 expected_results.size() == 0))
            @(posedge i_clk);
    endtask

    initial begin
        error_count = 0;
        quiet_cycles = 0;
        in_taken = 0;
        hold_requests = 0;
        send_idle_pct = 9;
        recv_idle_pct = 56;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        i_in_req = '0;
        for (int i = 0; i < FRAMES; i++) begin
            tag_table[i] = 0; tag_page[i] = 0; dirty[i] = 0; recency[i] = 4'(i);
        end
        frames_used = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: close on empty, extremes, hits, unknown operation, full buffer eviction, closes
        add_request(OP_CLOSE, 4'hF, 0);
        add_request(OP_READ, 4'h0, 32'h0000_0000);
        add_request(OP_WRITE, 4'hF, 32'hFFFF_FFFF);
        add_request(OP_READ, 4'h0, 32'h0000_0000);
        add_request(OP_WRITE, 4'h0, 32'h0000_0000);
        add_request(OP_READ, 4'hF, 32'hFFFF_FFFF);
        add_request(OP_UNKNOWN, 4'h5, 32'hA5A5_5A5A);
        for (int i = 0; i < 16; i++)
            add_request(i[0] ? OP_WRITE : OP_READ, 4'(i % 3 + 1), 32'h5555_0000 + i);
        add_request(OP_CLOSE, 4'h1, 0);
        add_request(OP_CLOSE, 4'h0, 0);
        wait_until_drained();

        // pause with requests held before the random phases
        hold_requests = 1;
        repeat (3) @(posedge i_clk);
        hold_requests = 0;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 56; recv_idle_pct = 9;
            end else if (phase == 2) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int n = 0; n < 85; n++) add_random_request();
            for (int n = 0; n < 10; n++)
                add_request(OP_WRITE, 4'($urandom_range(4, 15)), $urandom);
            wait_until_drained();
        end

        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
